/* hw/rtl/sm2a_pkg.sv */
`timescale 1ns / 1ps
package sm2a_pkg;

  localparam int unsigned Width = 256;
  localparam int unsigned LimbW = 64;

  // p = 2^256 - 2^224 - 2^96 + 2^64 - 1
  localparam logic [Width-1:0] Prime = {
    64'hFFFFFFFEFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
    64'hFFFFFFFF00000000, 64'hFFFFFFFFFFFFFFFF
  };
  // Inversion exponent p - 2
  localparam logic [Width-1:0] InvExp = Prime - Width'(2);

  localparam logic [1:0] FuncAdd = 2'd0;
  localparam logic [1:0] FuncSub = 2'd1;
  localparam logic [1:0] FuncMul = 2'd2;
  localparam logic [1:0] FuncInv = 2'd3;

  typedef enum logic {
    MODE_ADD,
    MODE_SUB
  } mode_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [LimbW-1:0] operand_a_w0;
    logic [LimbW-1:0] operand_a_w1;
    logic [LimbW-1:0] operand_a_w2;
    logic [LimbW-1:0] operand_a_w3;
    logic [LimbW-1:0] operand_b_w0;
    logic [LimbW-1:0] operand_b_w1;
    logic [LimbW-1:0] operand_b_w2;
    logic [LimbW-1:0] operand_b_w3;
  } req_t;

  typedef struct packed {
    logic [LimbW-1:0] result_w0;
    logic [LimbW-1:0] result_w1;
    logic [LimbW-1:0] result_w2;
    logic [LimbW-1:0] result_w3;
  } rsp_t;

endpackage

/* hw/rtl/sm2a_stream_if.sv */
`timescale 1ns / 1ps
interface sm2a_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/sm2a_mod_unit.sv */
`timescale 1ns / 1ps
// Shared modular add / subtract with a single correction step.
module sm2a_mod_unit import sm2a_pkg::*; (
  input  mode_e            mode_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  output logic [Width-1:0] r_o
);

  logic [Width:0]   sum;
  logic [Width+1:0] red;
  logic [Width:0]   dif;
  logic [Width-1:0] fix;

  always_comb begin
    sum = {1'b0, x_i} + {1'b0, y_i};
    red = {1'b0, sum} - {2'b00, Prime};
    dif = {1'b0, x_i} - {1'b0, y_i};
    fix = dif[Width-1:0] + Prime;
    case (mode_i)
      MODE_ADD: r_o = red[Width+1] ? sum[Width-1:0] : red[Width-1:0];
      MODE_SUB: r_o = dif[Width] ? fix : dif[Width-1:0];
      default:  r_o = sum[Width-1:0];
    endcase
  end

endmodule

/* hw/rtl/sm2_prime_field_alu.sv */
`timescale 1ns / 1ps
// SM2 prime field ALU, modulus p = 2^256 - 2^224 - 2^96 + 2^64 - 1.
// in_i  : one transfer carries func and operands a, b (four 64-bit limbs each).
// out_o : one transfer per request carries the 256-bit result.
// All work runs through one 256-bit modular add/subtract unit under a sequencer;
// in_i.ready is high only while the sequencer is idle.
// Steps from input transfer to out_o.valid:
//   add, subtract : one unit pass in StExec, then StFin.
//   multiply      : one reduction pass each for a and b, then bit-serial
//                   double-and-add over the 256 bits of reduced a, a doubling
//                   per bit and an add per set bit, one unit pass per cycle.
//   invert        : 478 such multiplies (256 squarings and one per each of
//                   the 222 set bits of p-2) after a is reduced.
// Operands of multiply, and operand a of invert, are first reduced below p by one pass each.
// The result sits in an output register; if the receiver stalls, a finished
// result waits in the sequencer until that register frees, so nothing is lost.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// out_o.valid; no result in flight survives it.
module sm2_prime_field_alu import sm2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sm2a_stream_if.sink   in_i,
  sm2a_stream_if.source out_o
);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StExec   = 4'd1;
  localparam logic [3:0] StRedA   = 4'd2;
  localparam logic [3:0] StRedB   = 4'd3;
  localparam logic [3:0] StMulDbl = 4'd4;
  localparam logic [3:0] StMulAdd = 4'd5;
  localparam logic [3:0] StMulEnd = 4'd6;
  localparam logic [3:0] StFin    = 4'd7;

  logic [3:0]       state_q, state_d;
  logic [1:0]       func_q, func_d;
  logic [Width-1:0] op_a_q, op_a_d;   // base for invert
  logic [Width-1:0] op_b_q, op_b_d;   // running power for invert
  logic [Width-1:0] mx_q, mx_d;       // multiplier, scanned from its top bit
  logic [Width-1:0] my_q, my_d;
  logic [Width-1:0] macc_q, macc_d;
  logic [Width-1:0] res_q, res_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       ecnt_q, ecnt_d;
  logic             inv_mul_q, inv_mul_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;

  mode_e            u_mode;
  logic [Width-1:0] u_x, u_y, u_r;
  logic             in_xfer;

  sm2a_mod_unit u_unit (
    .mode_i (u_mode),
    .x_i    (u_x),
    .y_i    (u_y),
    .r_o    (u_r)
  );

  assign in_i.ready  = (state_q == StIdle);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Operand selection for the shared unit
  always_comb begin
    u_mode = MODE_ADD;
    u_x    = macc_q;
    u_y    = my_q;
    case (state_q)
      StExec: begin
        u_mode = (func_q == FuncSub) ? MODE_SUB : MODE_ADD;
        u_x    = op_a_q;
        u_y    = op_b_q;
      end
      StRedA: begin
        u_x = op_a_q;
        u_y = '0;
      end
      StRedB: begin
        u_x = op_b_q;
        u_y = '0;
      end
      StMulDbl: begin
        u_x = macc_q;
        u_y = macc_q;
      end
      default: begin
        u_x = macc_q;
        u_y = my_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    mx_d        = mx_q;
    my_d        = my_q;
    macc_d      = macc_q;
    res_d       = res_q;
    cnt_d       = cnt_q;
    ecnt_d      = ecnt_q;
    inv_mul_d   = inv_mul_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          func_d = in_i.data.func;
          op_a_d = {in_i.data.operand_a_w3, in_i.data.operand_a_w2,
                    in_i.data.operand_a_w1, in_i.data.operand_a_w0};
          op_b_d = {in_i.data.operand_b_w3, in_i.data.operand_b_w2,
                    in_i.data.operand_b_w1, in_i.data.operand_b_w0};
          state_d = (in_i.data.func == FuncAdd || in_i.data.func == FuncSub)
                    ? StExec : StRedA;
        end
      end
      StExec: begin
        res_d   = u_r;
        state_d = StFin;
      end
      StRedA: begin
        op_a_d = u_r;
        if (func_q == FuncMul) begin
          state_d = StRedB;
        end else begin
          // invert: power starts at one, first step squares it
          op_b_d    = Width'(1);
          ecnt_d    = 8'd255;
          inv_mul_d = 1'b0;
          mx_d      = Width'(1);
          my_d      = Width'(1);
          macc_d    = '0;
          cnt_d     = 8'd255;
          state_d   = StMulDbl;
        end
      end
      StRedB: begin
        op_b_d  = u_r;
        mx_d    = op_a_q;
        my_d    = u_r;
        macc_d  = '0;
        cnt_d   = 8'd255;
        state_d = StMulDbl;
      end
      StMulDbl: begin
        macc_d = u_r;
        if (mx_q[Width-1]) begin
          state_d = StMulAdd;
        end else if (cnt_q == '0) begin
          state_d = StMulEnd;
        end else begin
          cnt_d = cnt_q - 8'd1;
          mx_d  = mx_q << 1;
        end
      end
      StMulAdd: begin
        macc_d = u_r;
        if (cnt_q == '0) begin
          state_d = StMulEnd;
        end else begin
          cnt_d   = cnt_q - 8'd1;
          mx_d    = mx_q << 1;
          state_d = StMulDbl;
        end
      end
      StMulEnd: begin
        if (func_q == FuncMul) begin
          res_d   = macc_q;
          state_d = StFin;
        end else begin
          op_b_d = macc_q;
          if (!inv_mul_q && InvExp[ecnt_q]) begin
            // square done, exponent bit set: multiply by base
            inv_mul_d = 1'b1;
            mx_d      = macc_q;
            my_d      = op_a_q;
            macc_d    = '0;
            cnt_d     = 8'd255;
            state_d   = StMulDbl;
          end else if (ecnt_q == '0) begin
            res_d   = macc_q;
            state_d = StFin;
          end else begin
            inv_mul_d = 1'b0;
            ecnt_d    = ecnt_q - 8'd1;
            mx_d      = macc_q;
            my_d      = macc_q;
            macc_d    = '0;
            cnt_d     = 8'd255;
            state_d   = StMulDbl;
          end
        end
      end
      StFin: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = '{result_w0: res_q[63:0],    result_w1: res_q[127:64],
                          result_w2: res_q[191:128], result_w3: res_q[255:192]};
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ecnt_q      <= '0;
      inv_mul_q   <= 1'b0;
      func_q      <= FuncAdd;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ecnt_q      <= ecnt_d;
      inv_mul_q   <= inv_mul_d;
      func_q      <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_a_q     <= op_a_d;
    op_b_q     <= op_b_d;
    mx_q       <= mx_d;
    my_q       <= my_d;
    macc_q     <= macc_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != StIdle)
    else $error("sequencer idle straight after an input transfer");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StFin)
    else $error("result raised outside the finish step");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMulAdd |-> macc_q < Prime)
    else $error("multiply accumulator not reduced");

  a_add_only_on_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMulAdd |-> $past(state_q) == StMulDbl && $past(mx_q[Width-1]))
    else $error("add step without a multiplier bit");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Stream-level testbench for the SM2 prime field ALU.
// A predictor works out each modular result from 256- and 512-bit vector arithmetic.
// Each predicted result joins a queue when its request transfer is accepted.
// Every output transfer is checked limb by limb against the oldest entry.
// Both ends idle at random. One phase holds the receiver off for a long
// stretch, so the block fills up and stalls its input.
module testbench;
  import sm2a_pkg::*;

  localparam int unsigned HalfPeriod = 5;
  // The limit must sit well above the longest inversion, which makes no
  // transfer while it runs.
  localparam int unsigned IdleLimit = 800000;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned HoldOffCycles = 400;

  logic clk_i;
  logic rst_ni;

  sm2a_stream_if #(.T(req_t)) req_if ();
  sm2a_stream_if #(.T(rsp_t)) rsp_if ();

  sm2_prime_field_alu i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  rsp_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit hold_off_req = 1'b0;
  bit no_gaps = 1'b0;

  always begin
    clk_i = 1'b1;
    #HalfPeriod;
    clk_i = 1'b0;
    #HalfPeriod;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [Width-1:0] mod_mul(logic [Width-1:0] a, logic [Width-1:0] b);
    logic [2*Width-1:0] prod;
    logic [2*Width-1:0] modulus;
    logic [2*Width-1:0] rem;
    prod    = {{Width{1'b0}}, a} * {{Width{1'b0}}, b};
    modulus = {{Width{1'b0}}, Prime};
    rem     = prod % modulus;
    return rem[Width-1:0];
  endfunction

  function automatic rsp_t field_result(req_t req);
    logic [Width-1:0] a;
    logic [Width-1:0] b;
    logic [Width-1:0] r;
    logic [Width:0]   wide;
    rsp_t rsp;
    a = {req.operand_a_w3, req.operand_a_w2, req.operand_a_w1, req.operand_a_w0};
    b = {req.operand_b_w3, req.operand_b_w2, req.operand_b_w1, req.operand_b_w0};
    case (req.func)
      FuncAdd: begin
        // One conditional subtraction of p; the 256-bit result wraps.
        wide = {1'b0, a} + {1'b0, b};
        if (wide[Width] || wide[Width-1:0] >= Prime) begin
          r = wide[Width-1:0] - Prime;
        end else begin
          r = wide[Width-1:0];
        end
      end
      FuncSub: begin
        r = a - b;
        if (a < b) begin
          r = r + Prime;
        end
      end
      FuncMul: begin
        r = mod_mul(a, b);
      end
      default: begin
        // a^(p-2), left to right; zero stays zero.
        r = Width'(1);
        for (int i = Width - 1; i >= 0; i--) begin
          r = mod_mul(r, r);
          if (InvExp[i]) begin
            r = mod_mul(r, a);
          end
        end
      end
    endcase
    rsp.result_w0 = r[63:0];
    rsp.result_w1 = r[127:64];
    rsp.result_w2 = r[191:128];
    rsp.result_w3 = r[255:192];
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [Width-1:0] rand_operand();
    logic [Width-1:0] v;
    for (int i = 0; i < Width / 32; i++) begin
      v[i*32 +: 32] = $urandom;
    end
    case ($urandom_range(0, 19))
      0: v = '0;
      1: v = Prime - Width'(1);
      2: v = Prime;
      3: v = '1;
      4: v = Width'($urandom_range(0, 7));
      // Unreduced but near the modulus.
      5: v = Prime + Width'($urandom_range(0, 255));
      default: if (v >= Prime && $urandom_range(0, 1)) v = v - Prime;
    endcase
    return v;
  endfunction

  function automatic req_t make_req(logic [1:0] func, logic [Width-1:0] a,
                                    logic [Width-1:0] b);
    req_t req;
    req.func = func;
    {req.operand_a_w3, req.operand_a_w2, req.operand_a_w1, req.operand_a_w0} = a;
    {req.operand_b_w3, req.operand_b_w2, req.operand_b_w1, req.operand_b_w0} = b;
    return req;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_request(req_t req);
    int unsigned gap;
    gap = rand_gap();
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = req;
    do begin
      @(posedge clk_i);
    end while (!req_if.ready);
    expected_results.push_back(field_result(req));
    @(negedge clk_i);
  endtask

  task automatic idle_request();
    req_if.valid = 1'b0;
    req_if.data  = '0;
  endtask

  task automatic wait_drained();
    idle_request();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        rsp_if.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        hold_off_req = 1'b0;
      end
      if (no_gaps) begin
        rsp_if.ready = 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0:       rsp_if.ready = 1'b0;
          1, 2, 3: begin
            // short stall
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk_i);
            rsp_if.ready = 1'b1;
          end
          4:       begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clk_i);
            rsp_if.ready = 1'b1;
          end
          default: rsp_if.ready = 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", got);
        fail_count++;
      end else begin
        exp_rsp = expected_results.pop_front();
        if (got.result_w0 !== exp_rsp.result_w0) begin
          $error("result_w0: expected %h, got %h", exp_rsp.result_w0, got.result_w0);
          fail_count++;
        end
        if (got.result_w1 !== exp_rsp.result_w1) begin
          $error("result_w1: expected %h, got %h", exp_rsp.result_w1, got.result_w1);
          fail_count++;
        end
        if (got.result_w2 !== exp_rsp.result_w2) begin
          $error("result_w2: expected %h, got %h", exp_rsp.result_w2, got.result_w2);
          fail_count++;
        end
        if (got.result_w3 !== exp_rsp.result_w3) begin
          $error("result_w3: expected %h, got %h", exp_rsp.result_w3, got.result_w3);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_add_sub_edges();
    send_request(make_req(FuncAdd, '0, '0));
    send_request(make_req(FuncAdd, Prime - Width'(1), Width'(1)));    // sum equals p
    send_request(make_req(FuncAdd, Prime - Width'(1), Prime - Width'(1)));
    send_request(make_req(FuncAdd, '1, '1));                          // carry out
    send_request(make_req(FuncAdd, Prime - Width'(2), Width'(1)));    // just below p
    send_request(make_req(FuncSub, '0, Width'(1)));                   // borrow
    send_request(make_req(FuncSub, Width'(5), Width'(5)));
    send_request(make_req(FuncSub, '0, '1));                          // unreduced, wraps
    send_request(make_req(FuncSub, Prime - Width'(1), '0));
  endtask

  task automatic test_mul_edges();
    send_request(make_req(FuncMul, '0, '1));
    send_request(make_req(FuncMul, Width'(1), Prime - Width'(1)));
    send_request(make_req(FuncMul, Prime - Width'(1), Prime - Width'(1)));
    send_request(make_req(FuncMul, '1, '1));                          // unreduced operands
    send_request(make_req(FuncMul, Prime, rand_operand()));           // multiple of p
  endtask

  task automatic test_invert();
    // Each inversion is a long run of multiplies: keep to two.
    send_request(make_req(FuncInv, '0, '1));                          // zero maps to zero
    send_request(make_req(FuncInv, rand_operand() | Width'(1), rand_operand()));
  endtask

  task automatic test_random();
    logic [1:0] func;
    for (int n = 0; n < RandomItems; n++) begin
      // Mostly add and subtract; multiply is slow.
      func = ($urandom_range(0, 9) == 0) ? FuncMul :
             ($urandom_range(0, 1) ? FuncAdd : FuncSub);
      no_gaps = (n >= 600 && n < 800);
      send_request(make_req(func, rand_operand(), rand_operand()));
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_stall();
    wait_drained();
    hold_off_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_request(make_req($urandom_range(0, 1) ? FuncAdd : FuncSub,
                            rand_operand(), rand_operand()));
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (5) @(negedge clk_i);
    send_request(make_req(FuncMul, rand_operand(), rand_operand()));
    send_request(make_req(FuncAdd, rand_operand(), rand_operand()));
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_request();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_add_sub_edges();
    test_mul_edges();
    test_invert();
    test_output_stall();
    test_drain_pause();
    test_random();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
